// ===== rtl/til_pkg.sv =====
// shared types and constants of the interpolating table lookup
`default_nettype none
package til_pkg;
    localparam int VW = 32;
    localparam int IW = 8;

    typedef struct packed {
        logic          func;
        logic [IW-1:0] entry_index;
        logic [VW-1:0] x_value;
        logic [VW-1:0] y_value;
    } t_req;

    typedef struct packed {
        logic [VW-1:0] y_result;
        logic [2:0]    status;
    } t_rsp;

    localparam logic [2:0] ST_WRITTEN = 3'd0;
    localparam logic [2:0] ST_BELOW   = 3'd1;
    localparam logic [2:0] ST_ABOVE   = 3'd2;
    localparam logic [2:0] ST_EXACT   = 3'd3;
    localparam logic [2:0] ST_INTERP  = 3'd4;
    localparam logic [2:0] ST_STEP    = 3'd5;
    localparam logic [2:0] ST_BADWIN  = 3'd6;

    localparam logic [1:0] REG_FIRST  = 2'd0;
    localparam logic [1:0] REG_LAST   = 2'd1;
    localparam logic [1:0] REG_INTERP = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
endpackage
`default_nettype wire

// ===== rtl/til_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module til_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/til_muldiv.sv =====
// iterative floor(a*t/d) for unsigned 32-bit operands, one bit a cycle
`default_nettype none
module til_muldiv
    import til_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VW-1:0] i_a,
    input  wire logic [VW-1:0] i_t,
    input  wire logic [VW-1:0] i_d,
    output logic               o_done,
    output logic      [VW-1:0] o_q
);
    localparam int PW = 2 * VW;

    logic [PW-1:0]     r_num;
    logic [VW:0]       r_rem;
    logic [VW-1:0]     r_d;
    logic [VW-1:0]     r_q;
    logic [6:0]        r_cnt;
    logic              r_mul;
    logic              r_busy;
    logic [VW-1:0]     r_a;
    logic [VW-1:0]     r_t;
    logic [VW:0]       w_sh;

    // operands are latched at start, the product is formed next, then 64 restoring steps
    assign w_sh = {r_rem[VW-1:0], r_num[PW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_t    <= i_t;
                r_d    <= i_d;
                r_mul  <= 1'b1;
                r_busy <= 1'b0;
            end else if (r_mul) begin
                r_num  <= r_a * r_t;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= 7'(PW);
                r_mul  <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[PW-2:0], 1'b0};
                if (w_sh >= {1'b0, r_d}) begin
                    r_rem <= w_sh - {1'b0, r_d};
                    r_q   <= {r_q[VW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[VW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== rtl/table_interpolating_lookup.sv =====
// top level of the interpolating table lookup
`default_nettype none
// A table of x,y sample pairs (signed Q16.16) held in one synchronous RAM that stores
// each pair as one word. A request with func 0 writes a pair and answers status 0;
// with func 1 it looks up x_value over the window first_index..last_index (x ascending):
// clamps at the ends, bisects otherwise, answers an exact hit, the lower y, or a linear
// interpolation; a write or a bad window (first above last, or last past the table) is
// answered from the idle state. A lookup reads the first entry, then the last, then the
// mid entry per halving of the window, then the lower pair; interpolation then reads the
// upper pair and runs the product and 64 steps in the bit-serial divider.
// One request is in work at a time; the next one is taken once the block is idle and the
// result register is empty or being read out in that same cycle.
module table_interpolating_lookup
    import til_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_req        i_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_rsp             o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDF   = 9'b000000010,
        S_CHKF  = 9'b000000100,
        S_CHKL  = 9'b000001000,
        S_BIS   = 9'b000010000,
        S_CHKM  = 9'b000100000,
        S_RDLO  = 9'b001000000,
        S_RDUP  = 9'b010000000,
        S_DIV   = 9'b100000000
    } t_state;

    t_state        r_state;
    t_req          r_req;
    logic [7:0]    r_first, r_last;
    logic          r_interp;
    logic [8:0]    r_lo, r_up;
    logic [VW-1:0] r_x0, r_y0;
    logic          r_obusy;
    t_rsp          r_rsp;
    logic          r_neg;
    logic          r_wait;

    logic              w_we;
    logic [AW-1:0]     w_addr;
    logic [2*VW-1:0]   w_rdata;
    logic [VW-1:0]     w_rx, w_ry;
    logic              w_start;
    logic [VW-1:0]     w_ma, w_mt, w_md, w_q;
    logic              w_done;
    logic              w_accept;
    logic              w_free;
    logic [8:0]        w_mid;
    logic              w_badwin;

    // ---- configuration port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 8'd0;
            r_last   <= 8'd255;
            r_interp <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_FIRST:  r_first  <= pwdata[7:0];
                REG_LAST:   r_last   <= pwdata[7:0];
                REG_INTERP: r_interp <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_FIRST:  prdata = {24'd0, r_first};
            REG_LAST:   prdata = {24'd0, r_last};
            REG_INTERP: prdata = {31'd0, r_interp};
            default:    prdata = '0;
        endcase
    end

    // ---- handshake: accept when idle and the output register can take a result
    assign w_free   = !r_obusy || !i_stall;
    assign o_stall  = !(r_state == S_IDLE && w_free);
    assign w_accept = i_valid && !o_stall;
    assign o_valid  = r_obusy;
    assign o_rsp    = r_rsp;

    // ---- table memory, x in the upper half of each word
    assign w_rx = w_rdata[2*VW-1:VW];
    assign w_ry = w_rdata[VW-1:0];
    assign w_badwin = (r_first > r_last) || (int'(r_last) >= TABLE_DEPTH);
    assign w_mid = (r_lo + r_up) >> 1;

    always_comb begin
        w_we   = 1'b0;
        w_addr = r_lo[AW-1:0];
        if (w_accept && i_req.func == FUNC_WRITE) begin
            w_we   = (int'(i_req.entry_index) < TABLE_DEPTH);
            w_addr = AW'(i_req.entry_index);
        end else begin
            case (r_state)
                S_IDLE: w_addr = AW'(r_first);
                S_RDF:  w_addr = AW'(r_first);
                S_CHKF: w_addr = AW'(r_last);
                S_BIS:  w_addr = w_mid[AW-1:0];
                S_CHKM: w_addr = w_mid[AW-1:0];
                S_RDLO: w_addr = r_wait ? r_lo[AW-1:0] : AW'(r_lo + 9'd1);
                S_RDUP: w_addr = AW'(r_lo + 9'd1);
                default: w_addr = r_lo[AW-1:0];
            endcase
        end
    end

    til_ram #(.WIDTH(2 * VW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata({i_req.x_value, i_req.y_value}),
        .o_rdata(w_rdata)
    );

    // ---- divider operands come from lower pair and the upper entry on the bus
    assign w_start = (r_state == S_RDUP) && !r_wait;
    assign w_ma = $signed(w_ry) < $signed(r_y0) ? r_y0 - w_ry : w_ry - r_y0;
    assign w_mt = r_req.x_value - r_x0;
    assign w_md = w_rx - r_x0;

    til_muldiv u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_a    (w_ma),
        .i_t    (w_mt),
        .i_d    (w_md),
        .o_done (w_done),
        .o_q    (w_q)
    );

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_obusy <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            // result leaves unless a write or bad window answer refills it this cycle
            if (r_obusy && !i_stall &&
                !(w_accept && (i_req.func == FUNC_WRITE || w_badwin))) begin
                r_obusy <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req <= i_req;
                        if (i_req.func == FUNC_WRITE) begin
                            r_rsp   <= '{y_result: '0, status: ST_WRITTEN};
                            r_obusy <= 1'b1;
                        end else if (w_badwin) begin
                            r_rsp   <= '{y_result: '0, status: ST_BADWIN};
                            r_obusy <= 1'b1;
                        end else begin
                            r_state <= S_RDF;
                        end
                    end
                end
                // first entry address goes out now
                S_RDF: r_state <= S_CHKF;
                S_CHKF: begin
                    if (!($signed(w_rx) < $signed(r_req.x_value))) begin
                        r_rsp   <= '{y_result: w_ry, status: ST_BELOW};
                        r_obusy <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CHKL;
                    end
                end
                S_CHKL: begin
                    if (!($signed(r_req.x_value) < $signed(w_rx))) begin
                        r_rsp   <= '{y_result: w_ry, status: ST_ABOVE};
                        r_obusy <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_lo    <= {1'b0, r_first};
                        r_up    <= {1'b0, r_last};
                        r_state <= S_BIS;
                    end
                end
                S_BIS: begin
                    // mid address issued this cycle
                    if (r_up - r_lo > 9'd1) begin
                        r_state <= S_CHKM;
                    end else begin
                        r_state <= S_RDLO;
                        r_wait  <= 1'b1;
                    end
                end
                S_CHKM: begin
                    if (!($signed(r_req.x_value) < $signed(w_rx))) begin
                        r_lo <= w_mid;
                    end else begin
                        r_up <= w_mid;
                    end
                    r_state <= S_BIS;
                end
                S_RDLO: begin
                    // lo entry read is issued in the wait cycle, lo+1 after it
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else begin
                        r_x0 <= w_rx;
                        r_y0 <= w_ry;
                        if (w_rx == r_req.x_value) begin
                            r_rsp   <= '{y_result: w_ry, status: ST_EXACT};
                            r_obusy <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (!r_interp) begin
                            r_rsp   <= '{y_result: w_ry, status: ST_STEP};
                            r_obusy <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RDUP;
                            r_wait  <= 1'b1;
                        end
                    end
                end
                S_RDUP: begin
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else begin
                        r_neg   <= $signed(w_ry) < $signed(r_y0);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_rsp   <= '{y_result: r_neg ? r_y0 - w_q : r_y0 + w_q,
                                     status: ST_INTERP};
                        r_obusy <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
